// ===== rtl/pcxrd_pkg.sv =====
// Shared types and constants of the PCX run-length palette decoder.
`default_nettype none
package pcxrd_pkg;

    // Field widths
    localparam int unsigned COL_W   = 9;
    localparam int unsigned ROW_W   = 8;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned COMP_W  = 8;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned RGB_W   = 3 * COMP_W;
    localparam int unsigned PAL_DEPTH = 1 << IDX_W;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = COL_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAST_COLUMN = 1'b0,
        CFG_LAST_ROW    = 1'b1
    } t_cfg_idx;

    localparam logic [COL_W-1:0] LAST_COLUMN_RST = 9'd319;
    localparam logic [ROW_W-1:0] LAST_ROW_RST    = 8'd199;

    // Request kinds
    typedef enum logic {
        REQ_PALETTE = 1'b0,
        REQ_DATA    = 1'b1
    } t_req;

    // Stream byte coding
    localparam logic [1:0]        RUN_MARK     = 2'b11;
    localparam logic [COMP_W-1:0] OPAQUE_ALPHA = 8'hFF;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic pal_wr;     // write one palette entry
        logic set_mark;   // latch run count from a marker byte
        logic load_run;   // start a run: read palette, load pixel count
        logic pix_step;   // one pixel transferred
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic marker;        // incoming byte is a run marker
        logic awaiting;      // next data byte is a run colour
        logic pending_zero;  // latched run count is zero
        logic finished;      // last row done, data ignored
        logic last_pix;      // current pixel ends the run or the row
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/pcxrd_if.sv =====
// Valid/ready channel interfaces for the decoder's request and pixel streams.
`default_nettype none
interface pcxrd_in_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic [pcxrd_pkg::IDX_W-1:0]       pal_index;
    logic [pcxrd_pkg::COMP_W-1:0]      pal_red;
    logic [pcxrd_pkg::COMP_W-1:0]      pal_green;
    logic [pcxrd_pkg::COMP_W-1:0]      pal_blue;
    logic [pcxrd_pkg::IDX_W-1:0]       data_byte;

    modport source (
        output valid, req_type, pal_index, pal_red, pal_green, pal_blue, data_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, pal_index, pal_red, pal_green, pal_blue, data_byte,
        output ready
    );
endinterface

interface pcxrd_out_if;
    logic                              valid;
    logic                              ready;
    logic [pcxrd_pkg::COMP_W-1:0]      red;
    logic [pcxrd_pkg::COMP_W-1:0]      green;
    logic [pcxrd_pkg::COMP_W-1:0]      blue;
    logic [pcxrd_pkg::COMP_W-1:0]      alpha;
    logic [pcxrd_pkg::COL_W-1:0]       pix_column;
    logic [pcxrd_pkg::ROW_W-1:0]       pix_row;
    logic                              last_of_run;
    logic                              image_done;

    modport source (
        output valid, red, green, blue, alpha, pix_column, pix_row, last_of_run,
               image_done,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue, alpha, pix_column, pix_row, last_of_run,
               image_done,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/pcxrd_ctrl.sv =====
// Controller: accepts requests and sequences the pixels of one run.
`default_nettype none
module pcxrd_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_req_type,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire pcxrd_pkg::t_stat i_stat,
    output pcxrd_pkg::t_cmd       o_cmd
);

    pcxrd_pkg::t_state r_state, n_state;
    logic accept, data_acc;

    assign o_in_ready  = (r_state == pcxrd_pkg::ST_IDLE);
    assign o_out_valid = (r_state == pcxrd_pkg::ST_RUN);
    assign accept      = i_in_valid & o_in_ready;
    assign data_acc    = accept & (i_req_type == pcxrd_pkg::REQ_DATA) & ~i_stat.finished;

    // Command decode
    always_comb begin
        o_cmd.pal_wr   = accept & (i_req_type == pcxrd_pkg::REQ_PALETTE);
        o_cmd.set_mark = data_acc & ~i_stat.awaiting & i_stat.marker;
        o_cmd.load_run = data_acc & (i_stat.awaiting | ~i_stat.marker);
        o_cmd.pix_step = o_out_valid & i_out_ready;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcxrd_pkg::ST_IDLE: begin
                // a run of count zero only consumes its colour byte
                if (o_cmd.load_run && !(i_stat.awaiting && i_stat.pending_zero)) begin
                    n_state = pcxrd_pkg::ST_RUN;
                end
            end
            pcxrd_pkg::ST_RUN: begin
                if (o_cmd.pix_step && i_stat.last_pix) begin
                    n_state = pcxrd_pkg::ST_IDLE;
                end
            end
            default: n_state = pcxrd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcxrd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pcxrd_dp.sv =====
// Datapath: palette memory, run state, pixel position and configuration.
`default_nettype none
module pcxrd_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire pcxrd_pkg::t_cmd                    i_cmd,
    output pcxrd_pkg::t_stat                        o_stat,
    // configuration writes
    input  wire logic                               i_cfg_we,
    input  wire logic [pcxrd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pcxrd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // request payload
    input  wire logic [pcxrd_pkg::IDX_W-1:0]        i_pal_index,
    input  wire logic [pcxrd_pkg::COMP_W-1:0]       i_pal_red,
    input  wire logic [pcxrd_pkg::COMP_W-1:0]       i_pal_green,
    input  wire logic [pcxrd_pkg::COMP_W-1:0]       i_pal_blue,
    input  wire logic [pcxrd_pkg::IDX_W-1:0]        i_data_byte,
    // pixel payload
    output logic [pcxrd_pkg::COMP_W-1:0]            o_red,
    output logic [pcxrd_pkg::COMP_W-1:0]            o_green,
    output logic [pcxrd_pkg::COMP_W-1:0]            o_blue,
    output logic [pcxrd_pkg::COMP_W-1:0]            o_alpha,
    output logic [pcxrd_pkg::COL_W-1:0]             o_pix_column,
    output logic [pcxrd_pkg::ROW_W-1:0]             o_pix_row,
    output logic                                    o_last_of_run,
    output logic                                    o_image_done
);

    logic [pcxrd_pkg::RGB_W-1:0]  r_pal_mem [pcxrd_pkg::PAL_DEPTH];
    logic [pcxrd_pkg::RGB_W-1:0]  r_rgb;
    logic [pcxrd_pkg::COL_W-1:0]  r_last_column;
    logic [pcxrd_pkg::ROW_W-1:0]  r_last_row;
    logic [pcxrd_pkg::COL_W-1:0]  r_column;
    logic [pcxrd_pkg::ROW_W-1:0]  r_row;
    logic [pcxrd_pkg::CNT_W-1:0]  r_pending;
    logic [pcxrd_pkg::CNT_W-1:0]  r_remaining;
    logic                         r_awaiting;
    logic                         r_finished;
    logic                         row_done, last_row_hit;

    // Palette memory: write on palette transfer, registered read on run start
    always_ff @(posedge i_clk) begin
        if (i_cmd.pal_wr) begin
            r_pal_mem[i_pal_index] <= {i_pal_red, i_pal_green, i_pal_blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_run) begin
            r_rgb <= r_pal_mem[i_data_byte];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_column <= pcxrd_pkg::LAST_COLUMN_RST;
            r_last_row    <= pcxrd_pkg::LAST_ROW_RST;
        end else if (i_cfg_we) begin
            case (pcxrd_pkg::t_cfg_idx'(i_cfg_idx))
                pcxrd_pkg::CFG_LAST_COLUMN: r_last_column <= i_cfg_data;
                pcxrd_pkg::CFG_LAST_ROW:    r_last_row    <= i_cfg_data[pcxrd_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    assign row_done     = (r_column >= r_last_column);
    assign last_row_hit = (r_row >= r_last_row);

    // Run state and pixel position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting  <= 1'b0;
            r_pending   <= '0;
            r_remaining <= '0;
            r_column    <= '0;
            r_row       <= '0;
            r_finished  <= 1'b0;
        end else begin
            if (i_cmd.set_mark) begin
                r_pending  <= i_data_byte[pcxrd_pkg::CNT_W-1:0];
                r_awaiting <= 1'b1;
            end
            if (i_cmd.load_run) begin
                r_remaining <= r_awaiting ? r_pending : pcxrd_pkg::CNT_W'(1);
                r_awaiting  <= 1'b0;
            end
            if (i_cmd.pix_step) begin
                r_remaining <= r_remaining - pcxrd_pkg::CNT_W'(1);
                if (row_done) begin
                    // end of row: rest of the run is dropped
                    r_column <= '0;
                    if (last_row_hit) begin
                        r_finished <= 1'b1;
                    end else begin
                        r_row <= r_row + pcxrd_pkg::ROW_W'(1);
                    end
                end else begin
                    r_column <= r_column + pcxrd_pkg::COL_W'(1);
                end
            end
        end
    end

    // Status
    always_comb begin
        o_stat.marker       = (i_data_byte[pcxrd_pkg::IDX_W-1 -: 2] == pcxrd_pkg::RUN_MARK);
        o_stat.awaiting     = r_awaiting;
        o_stat.pending_zero = (r_pending == '0);
        o_stat.finished     = r_finished;
        o_stat.last_pix     = row_done || (r_remaining == pcxrd_pkg::CNT_W'(1));
    end

    // Pixel payload
    assign o_red         = r_rgb[pcxrd_pkg::RGB_W-1 -: pcxrd_pkg::COMP_W];
    assign o_green       = r_rgb[pcxrd_pkg::COMP_W +: pcxrd_pkg::COMP_W];
    assign o_blue        = r_rgb[pcxrd_pkg::COMP_W-1:0];
    assign o_alpha       = pcxrd_pkg::OPAQUE_ALPHA;
    assign o_pix_column  = r_column;
    assign o_pix_row     = r_row;
    assign o_last_of_run = o_stat.last_pix;
    assign o_image_done  = row_done && last_row_hit;

endmodule
`default_nettype wire

// ===== rtl/pcx_rle_palette_decoder.sv =====
// Top level of the PCX run-length decoder with 8-bit palette.
//
// Request channel i_in: each transfer is either a palette write (req_type 0:
// pal_index and RGB) or one byte of the compressed stream (req_type 1).
// A byte with both top bits set is a run marker holding a count of 0..63;
// the next data byte is the colour index of that run. Other bytes are single
// pixels. Pixel channel o_out: one transfer per pixel, RGB from the palette,
// alpha 255, column and row, last_of_run on the final pixel of a byte,
// image_done on the pixel that ends the last row.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data set last_column and last_row;
// write only while no run is in progress.
// Timing: palette writes and run markers start no run. A pixel byte is taken
// and its palette read is registered, landing in the next cycle; then its run
// puts out one pixel per cycle with the receiver ready. The request side is
// not ready while pixels of a run are pending; the controller takes requests
// only when idle. A stalled receiver holds the current pixel unchanged.
// Reset (synchronous, active low) returns to row 0, column 0, clears any
// pending run and restores the default geometry; palette contents persist.
`default_nettype none
module pcx_rle_palette_decoder (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [pcxrd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pcxrd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pcxrd_in_if.sink                              i_in,
    pcxrd_out_if.source                           o_out
);

    pcxrd_pkg::t_cmd  cmd;
    pcxrd_pkg::t_stat stat;

    pcxrd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_req_type  (i_in.req_type),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pcxrd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_pal_index   (i_in.pal_index),
        .i_pal_red     (i_in.pal_red),
        .i_pal_green   (i_in.pal_green),
        .i_pal_blue    (i_in.pal_blue),
        .i_data_byte   (i_in.data_byte),
        .o_red         (o_out.red),
        .o_green       (o_out.green),
        .o_blue        (o_out.blue),
        .o_alpha       (o_out.alpha),
        .o_pix_column  (o_out.pix_column),
        .o_pix_row     (o_out.pix_row),
        .o_last_of_run (o_out.last_of_run),
        .o_image_done  (o_out.image_done)
    );

endmodule
`default_nettype wire

// ===== rtl/pcxrd_checker.sv =====
// Port-level checks of the decoder, bound to the top level.
`default_nettype none
module pcxrd_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_ready,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [pcxrd_pkg::COL_W-1:0]   i_pix_column,
    input  wire logic [pcxrd_pkg::ROW_W-1:0]   i_pix_row,
    input  wire logic                          i_last_of_run,
    input  wire logic                          i_image_done
);

    // requests are never taken while a pixel is offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("request side ready while a pixel is pending");

    // a stalled pixel keeps its position
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_pix_column) && $stable(i_pix_row)))
        else $error("stalled pixel changed");

    // the image-ending pixel also ends its run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_image_done) |-> i_last_of_run)
        else $error("image_done without last_of_run");

    // after the last pixel of a run the block returns to taking requests
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_last_of_run) |=> (!i_out_valid && i_in_ready))
        else $error("pixel offered after end of run");

endmodule

bind pcx_rle_palette_decoder pcxrd_checker u_pcxrd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_pix_column  (o_out.pix_column),
    .i_pix_row     (o_out.pix_row),
    .i_last_of_run (o_out.last_of_run),
    .i_image_done  (o_out.image_done)
);
`default_nettype wire
